// ===== sv/ffra_pkg.sv =====
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared field widths, operation and status codes, and beat types for the
// first-fit range allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

    localparam int OP_W     = 2;
    localparam int COUNT_W  = 11;
    localparam int START_W  = 10;
    localparam int FRAME_W  = 2;
    localparam int STATUS_W = 2;
    localparam int CAP_W    = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_PROC  = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_CAP = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CPU_ONLY = 2'd1;

    localparam logic [CAP_W-1:0] CAPACITY_RST = 11'd1024;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [COUNT_W-1:0] count;
        logic [START_W-1:0] block_start;
        logic [FRAME_W-1:0] frame;
    } t_in_beat;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [START_W-1:0]  alloc_start;
        logic [COUNT_W-1:0]  alloc_count;
        logic                alloc_cpu_only;
        logic [COUNT_W-1:0]  in_use;
    } t_out_beat;

    typedef struct packed {
        logic [CAP_W-1:0] capacity;
        logic             cpu_only;
    } t_cfg;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [COUNT_W-1:0] len;
    } t_pend_entry;

endpackage

// ===== sv/ffra_slot_map.sv =====
// ----------------------------------------------------------------------------
// ffra_slot_map
// One free bit per slot: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ffra_slot_map #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [$clog2(MAX_SLOTS)-1:0] i_waddr,
    input  logic                         i_wbit,
    input  logic [$clog2(MAX_SLOTS)-1:0] i_raddr,
    output logic                         o_rbit
);

    logic r_mem [MAX_SLOTS];
    logic r_rbit;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wbit;
        end
        r_rbit <= r_mem[i_raddr];
    end

    assign o_rbit = r_rbit;

endmodule

// ===== sv/ffra_pend_mem.sv =====
// ----------------------------------------------------------------------------
// ffra_pend_mem
// Deferred-free queue storage for all frames, one region per frame.
// ----------------------------------------------------------------------------
module ffra_pend_mem #(
    parameter int DEPTH = 192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  ffra_pkg::t_pend_entry    i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output ffra_pkg::t_pend_entry    o_rdata
);

    ffra_pkg::t_pend_entry r_mem [DEPTH];
    ffra_pkg::t_pend_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/ffra_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffra_ctrl
// Sequencer: clearing pass, first-fit scan and claim, free queueing and
// frame release, all through one slot counter and one run tracker.
// ----------------------------------------------------------------------------
module ffra_ctrl #(
    parameter int MAX_SLOTS     = 1024,
    parameter int FRAME_SLOTS   = 3,
    parameter int PENDING_DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ffra_pkg::t_cfg       i_cfg,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  ffra_pkg::t_in_beat   i_in_data,
    output logic                 o_res_valid,
    output ffra_pkg::t_out_beat  o_res,
    input  logic                 i_res_take
);

    localparam int SW  = $clog2(MAX_SLOTS);
    localparam int LW  = (SW + 1 > 12) ? SW + 1 : 12;
    localparam int FW  = $clog2(PENDING_DEPTH + 1);
    localparam int PD  = FRAME_SLOTS * PENDING_DEPTH;
    localparam int PAW = $clog2(PD);

    typedef enum logic [7:0] {
        S_CLEAR   = 8'b0000_0001,
        S_IDLE    = 8'b0000_0010,
        S_A_SCAN  = 8'b0000_0100,
        S_A_WRITE = 8'b0000_1000,
        S_P_RD    = 8'b0001_0000,
        S_P_WAIT  = 8'b0010_0000,
        S_P_FREE  = 8'b0100_0000,
        S_RESULT  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic [LW-1:0] r_idx, n_idx;
    logic          r_rv, n_rv;
    logic [FW-1:0] r_fill [FRAME_SLOTS];
    logic [FW-1:0] n_fill [FRAME_SLOTS];
    logic [ffra_pkg::COUNT_W-1:0] r_in_use, n_in_use;

    logic [SW-1:0]                 r_rs, n_rs;
    logic [LW-1:0]                 r_run_len, n_run_len;
    logic [LW-1:0]                 r_run_start, n_run_start;
    logic [ffra_pkg::OP_W-1:0]     r_op, n_op;
    logic [ffra_pkg::COUNT_W-1:0]  r_count, n_count;
    logic [ffra_pkg::FRAME_W-1:0]  r_frame, n_frame;
    logic [ffra_pkg::STATUS_W-1:0] r_status, n_status;
    logic [ffra_pkg::START_W-1:0]  r_astart, n_astart;
    logic [FW-1:0]                 r_e, n_e;
    logic [LW-1:0]                 r_end, n_end;

    logic [LW-1:0]   cap;
    logic [LW-1:0]   cap_in;
    logic [LW-1:0]   len1;
    logic [LW-1:0]   run_st;
    logic [LW-1:0]   free_sum;
    logic            issue;
    logic            accept;
    logic            granted;
    logic [ffra_pkg::FRAME_W-1:0] frame_sel;
    logic [FW-1:0]   sel_fill;
    logic            frame_bad;

    logic            map_we;
    logic [SW-1:0]   map_waddr;
    logic            map_wbit;
    logic            map_rbit;

    logic                  pend_we;
    logic [PAW-1:0]        pend_waddr;
    logic [PAW-1:0]        pend_raddr;
    ffra_pkg::t_pend_entry pend_wdata;
    ffra_pkg::t_pend_entry pend_rdata;

    ffra_slot_map #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wbit  (map_wbit),
        .i_raddr (r_idx[SW-1:0]),
        .o_rbit  (map_rbit)
    );

    ffra_pend_mem #(
        .DEPTH (PD)
    ) u_pend (
        .i_clk   (i_clk),
        .i_we    (pend_we),
        .i_waddr (pend_waddr),
        .i_wdata (pend_wdata),
        .i_raddr (pend_raddr),
        .o_rdata (pend_rdata)
    );

    assign cap_in     = LW'(i_cfg.capacity);
    assign cap        = (cap_in > LW'(MAX_SLOTS)) ? LW'(MAX_SLOTS) : cap_in;
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign frame_sel  = (r_state == S_IDLE) ? i_in_data.frame : r_frame;
    assign frame_bad  = (int'(frame_sel) >= FRAME_SLOTS);
    assign len1       = r_run_len + LW'(1);
    assign run_st     = (r_run_len == '0) ? LW'(r_rs) : r_run_start;
    assign free_sum   = LW'(pend_rdata.start) + LW'(pend_rdata.len);

    always_comb begin
        sel_fill = '0;
        for (int f = 0; f < FRAME_SLOTS; f++) begin
            if (int'(frame_sel) == f) begin
                sel_fill = r_fill[f];
            end
        end
    end

    assign pend_waddr = PAW'(i_in_data.frame) * PAW'(PENDING_DEPTH) + PAW'(sel_fill);
    assign pend_raddr = PAW'(r_frame) * PAW'(PENDING_DEPTH) + PAW'(r_e);
    assign pend_wdata = '{start: i_in_data.block_start, len: i_in_data.count};

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_rv        = 1'b0;
        n_fill      = r_fill;
        n_in_use    = r_in_use;
        n_rs        = r_idx[SW-1:0];
        n_run_len   = r_run_len;
        n_run_start = r_run_start;
        n_op        = r_op;
        n_count     = r_count;
        n_frame     = r_frame;
        n_status    = r_status;
        n_astart    = r_astart;
        n_e         = r_e;
        n_end       = r_end;
        map_we      = 1'b0;
        map_waddr   = r_idx[SW-1:0];
        map_wbit    = 1'b1;
        pend_we     = 1'b0;
        issue       = 1'b0;

        case (r_state)
            S_CLEAR: begin
                map_we = 1'b1;
                n_idx  = r_idx + LW'(1);
                if (r_idx == LW'(MAX_SLOTS - 1)) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_op     = i_in_data.operation;
                    n_count  = i_in_data.count;
                    n_frame  = i_in_data.frame;
                    n_status = ffra_pkg::ST_OK;
                    n_astart = '0;
                    n_state  = S_RESULT;
                    case (i_in_data.operation)
                        ffra_pkg::OP_ALLOC: begin
                            if (i_in_data.count == '0) begin
                                n_status = ffra_pkg::ST_ZERO;
                            end else if (LW'(r_in_use) + LW'(i_in_data.count) > cap) begin
                                n_status = ffra_pkg::ST_NO_CAP;
                            end else begin
                                n_idx     = '0;
                                n_run_len = '0;
                                n_state   = S_A_SCAN;
                            end
                        end
                        ffra_pkg::OP_FREE: begin
                            if (i_in_data.count == '0) begin
                                n_status = ffra_pkg::ST_ZERO;
                            end else if (frame_bad || sel_fill >= FW'(PENDING_DEPTH)) begin
                                n_status = ffra_pkg::ST_FULL;
                            end else begin
                                pend_we = 1'b1;
                                for (int f = 0; f < FRAME_SLOTS; f++) begin
                                    if (int'(i_in_data.frame) == f) begin
                                        n_fill[f] = r_fill[f] + FW'(1);
                                    end
                                end
                            end
                        end
                        ffra_pkg::OP_PROC: begin
                            if (!frame_bad) begin
                                n_e     = '0;
                                n_state = S_P_RD;
                            end
                        end
                        default: begin
                            n_status = ffra_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_A_SCAN: begin
                issue = (r_idx < cap);
                n_rv  = issue;
                if (issue) begin
                    n_idx = r_idx + LW'(1);
                end
                if (r_rv) begin
                    if (map_rbit) begin
                        n_run_len   = len1;
                        n_run_start = run_st;
                        if (len1 >= LW'(r_count)) begin
                            n_astart  = run_st[ffra_pkg::START_W-1:0];
                            n_idx     = run_st;
                            n_run_len = LW'(r_count);
                            n_rv      = 1'b0;
                            n_state   = S_A_WRITE;
                        end
                    end else begin
                        n_run_len = '0;
                    end
                end else if (!issue) begin
                    n_status = ffra_pkg::ST_NO_CAP;
                    n_state  = S_RESULT;
                end
            end
            S_A_WRITE: begin
                map_we    = 1'b1;
                map_wbit  = 1'b0;
                n_idx     = r_idx + LW'(1);
                n_run_len = r_run_len - LW'(1);
                if (r_run_len == LW'(1)) begin
                    n_in_use = r_in_use + r_count;
                    n_state  = S_RESULT;
                end
            end
            S_P_RD: begin
                if (r_e >= sel_fill) begin
                    for (int f = 0; f < FRAME_SLOTS; f++) begin
                        if (int'(r_frame) == f) begin
                            n_fill[f] = '0;
                        end
                    end
                    n_state = S_RESULT;
                end else begin
                    n_state = S_P_WAIT;
                end
            end
            S_P_WAIT: begin
                n_idx   = LW'(pend_rdata.start);
                n_end   = (free_sum > LW'(MAX_SLOTS)) ? LW'(MAX_SLOTS) : free_sum;
                n_state = S_P_FREE;
            end
            S_P_FREE: begin
                issue = (r_idx < r_end);
                n_rv  = issue;
                if (issue) begin
                    n_idx = r_idx + LW'(1);
                end
                if (r_rv && !map_rbit) begin
                    map_we    = 1'b1;
                    map_waddr = r_rs;
                    if (r_in_use != '0) begin
                        n_in_use = r_in_use - ffra_pkg::COUNT_W'(1);
                    end
                end
                if (!issue && !r_rv) begin
                    n_e     = r_e + FW'(1);
                    n_state = S_P_RD;
                end
            end
            S_RESULT: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_idx    <= '0;
            r_rv     <= 1'b0;
            r_in_use <= '0;
            for (int f = 0; f < FRAME_SLOTS; f++) begin
                r_fill[f] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_rv     <= n_rv;
            r_in_use <= n_in_use;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rs        <= n_rs;
        r_run_len   <= n_run_len;
        r_run_start <= n_run_start;
        r_op        <= n_op;
        r_count     <= n_count;
        r_frame     <= n_frame;
        r_status    <= n_status;
        r_astart    <= n_astart;
        r_e         <= n_e;
        r_end       <= n_end;
    end

    assign granted     = (r_op == ffra_pkg::OP_ALLOC) && (r_status == ffra_pkg::ST_OK);
    assign o_res_valid = (r_state == S_RESULT);

    always_comb begin
        o_res                = '0;
        o_res.status         = r_status;
        o_res.in_use         = r_in_use;
        if (granted) begin
            o_res.alloc_start    = r_astart;
            o_res.alloc_count    = r_count;
            o_res.alloc_cpu_only = i_cfg.cpu_only;
        end
    end

endmodule

// ===== sv/first_fit_range_allocator_top.sv =====
// ----------------------------------------------------------------------------
// first_fit_range_allocator_top
// First-fit slot range allocator with per-frame deferred free.
// ----------------------------------------------------------------------------
// One item at a time. After reset a clearing pass marks every slot free while
// input stalls. An allocate walks the slot map one slot per cycle up to the
// last slot of the first run that fits, then claims count slots one per
// cycle; an allocate that finds no run walks up to the usable capacity. A
// rejected allocate, a queued free, a no-op and processing of a frame beyond
// the last go straight to the result. Processing a frame walks each queued
// range within the map. The slot map is read or written one slot per cycle.
// A result beat waits in an output register, so the next input beat is taken
// while it is held.
// ----------------------------------------------------------------------------
module first_fit_range_allocator_top #(
    parameter int MAX_SLOTS     = 1024,
    parameter int FRAME_SLOTS   = 3,
    parameter int PENDING_DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  ffra_pkg::t_in_beat               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output ffra_pkg::t_out_beat              o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ffra_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ffra_pkg::CAP_W-1:0]       i_cfg_data
);

    ffra_pkg::t_cfg      r_cfg;
    logic                r_out_valid;
    ffra_pkg::t_out_beat r_out_data;
    logic                res_valid;
    ffra_pkg::t_out_beat res;
    logic                res_take;

    ffra_ctrl #(
        .MAX_SLOTS     (MAX_SLOTS),
        .FRAME_SLOTS   (FRAME_SLOTS),
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take)
    );

    assign o_cfg_ready = 1'b1;
    assign res_take    = res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.capacity <= ffra_pkg::CAPACITY_RST;
            r_cfg.cpu_only <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    ffra_pkg::CFG_CAPACITY: r_cfg.capacity <= i_cfg_data;
                    ffra_pkg::CFG_CPU_ONLY: r_cfg.cpu_only <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (res_take) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== tb/first_fit_range_allocator_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_range_allocator_top_tb
// Self-checking bench for the first-fit slot range allocator. A cycle-free
// model of the slot map, the frame free queues and the in-use count predicts
// every result beat. Directed beats cover the field extremes and the special
// cases. Random traffic then runs under several capacity and cpu_only
// settings, with sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module first_fit_range_allocator_top_tb;

    localparam int POOL_SLOTS     = 1024;
    localparam int FRAME_QUEUES   = 3;
    localparam int QUEUE_DEPTH    = 64;
    localparam int WATCHDOG_LIMIT = 300000;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_stall;
    ffra_pkg::t_in_beat             i_in_data;
    logic                           o_out_valid;
    logic                           i_out_stall;
    ffra_pkg::t_out_beat            o_out_data;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [ffra_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [ffra_pkg::CAP_W-1:0]     i_cfg_data;

    // pool model
    bit                         slot_free [POOL_SLOTS];
    ffra_pkg::t_pend_entry      frame_queue [FRAME_QUEUES][QUEUE_DEPTH];
    int                         queue_fill [FRAME_QUEUES];
    int                         slots_used;
    logic [ffra_pkg::CAP_W-1:0] cap_reg;
    bit                         cpu_only_reg;

    ffra_pkg::t_out_beat   pending_replies [$];
    ffra_pkg::t_pend_entry live_ranges [$];

    int send_idle_pct;
    int stall_pct;
    int error_count  = 0;
    int quiet_cycles = 0;

    first_fit_range_allocator_top #(
        .MAX_SLOTS    (POOL_SLOTS),
        .FRAME_SLOTS  (FRAME_QUEUES),
        .PENDING_DEPTH(QUEUE_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic ffra_pkg::t_out_beat compute_reply(input ffra_pkg::t_in_beat req);
        ffra_pkg::t_out_beat   r;
        ffra_pkg::t_pend_entry ent;
        int                    usable;
        int                    run_start;
        int                    run_len;
        int                    stop;
        bit                    granted;
        r = '0;
        case (req.operation)
            ffra_pkg::OP_ALLOC: begin
                usable = (cap_reg > POOL_SLOTS) ? POOL_SLOTS : int'(cap_reg);
                if (req.count == 0) begin
                    r.status = ffra_pkg::ST_ZERO;
                end else if (slots_used + int'(req.count) > usable) begin
                    r.status = ffra_pkg::ST_NO_CAP;
                end else begin
                    r.status  = ffra_pkg::ST_NO_CAP;
                    run_len   = 0;
                    run_start = 0;
                    granted   = 1'b0;
                    for (int i = 0; i < usable && !granted; i++) begin
                        if (slot_free[i]) begin
                            if (run_len == 0) run_start = i;
                            run_len++;
                            if (run_len >= int'(req.count)) begin
                                granted = 1'b1;
                            end
                        end else begin
                            run_len = 0;
                        end
                    end
                    if (granted) begin
                        for (int k = run_start; k < run_start + int'(req.count); k++) begin
                            slot_free[k] = 1'b0;
                        end
                        slots_used += int'(req.count);
                        r.status         = ffra_pkg::ST_OK;
                        r.alloc_start    = ffra_pkg::START_W'(run_start);
                        r.alloc_count    = req.count;
                        r.alloc_cpu_only = cpu_only_reg;
                        ent.start = ffra_pkg::START_W'(run_start);
                        ent.len   = req.count;
                        live_ranges = {live_ranges, ent};
                    end
                end
            end
            ffra_pkg::OP_FREE: begin
                if (req.count == 0) begin
                    r.status = ffra_pkg::ST_ZERO;
                end else if (req.frame >= FRAME_QUEUES ||
                             queue_fill[req.frame] >= QUEUE_DEPTH) begin
                    r.status = ffra_pkg::ST_FULL;
                end else begin
                    frame_queue[req.frame][queue_fill[req.frame]].start = req.block_start;
                    frame_queue[req.frame][queue_fill[req.frame]].len   = req.count;
                    queue_fill[req.frame]++;
                    r.status = ffra_pkg::ST_OK;
                end
            end
            ffra_pkg::OP_PROC: begin
                r.status = ffra_pkg::ST_OK;
                if (req.frame < FRAME_QUEUES) begin
                    for (int e = 0; e < queue_fill[req.frame]; e++) begin
                        ent  = frame_queue[req.frame][e];
                        stop = int'(ent.start) + int'(ent.len);
                        if (stop > POOL_SLOTS) stop = POOL_SLOTS;
                        for (int s = int'(ent.start); s < stop; s++) begin
                            if (!slot_free[s]) begin
                                slot_free[s] = 1'b1;
                                if (slots_used > 0) slots_used--;
                            end
                        end
                    end
                    queue_fill[req.frame] = 0;
                end
            end
            default: begin
                r.status = ffra_pkg::ST_OK;
            end
        endcase
        r.in_use = ffra_pkg::COUNT_W'(slots_used);
        return r;
    endfunction

    function automatic ffra_pkg::t_in_beat make_request(
        input logic [ffra_pkg::OP_W-1:0] op,
        input int cnt, input int start,
        input int frm);
        ffra_pkg::t_in_beat b;
        b.operation   = op;
        b.count       = ffra_pkg::COUNT_W'(cnt);
        b.block_start = ffra_pkg::START_W'(start);
        b.frame       = ffra_pkg::FRAME_W'(frm);
        return b;
    endfunction

    // Mostly well-formed traffic: small allocations, frees of granted ranges,
    // frame processing. The rest is arbitrary noise.
    function automatic ffra_pkg::t_in_beat random_request();
        ffra_pkg::t_in_beat    b;
        ffra_pkg::t_pend_entry ent;
        int                    roll;
        int                    pick;
        int                    idx;
        b.operation   = ffra_pkg::OP_ALLOC;
        b.count       = ffra_pkg::COUNT_W'($urandom);
        b.block_start = ffra_pkg::START_W'($urandom);
        b.frame       = ffra_pkg::FRAME_W'($urandom_range(2));
        roll = $urandom_range(99);
        if (roll < 45) begin
            pick = $urandom_range(99);
            if (pick < 72)      b.count = ffra_pkg::COUNT_W'($urandom_range(16, 1));
            else if (pick < 93) b.count = ffra_pkg::COUNT_W'($urandom_range(128, 17));
            else if (pick < 96) b.count = ffra_pkg::COUNT_W'($urandom_range(1024, 129));
            else if (pick < 98) b.count = ffra_pkg::COUNT_W'($urandom_range(2047, 1025));
            else                b.count = '0;
        end else if (roll < 75 && live_ranges.size() != 0) begin
            idx = $urandom_range(live_ranges.size() - 1);
            ent = live_ranges[idx];
            live_ranges.delete(idx);
            b.operation   = ffra_pkg::OP_FREE;
            b.block_start = ent.start;
            b.count       = ent.len;
        end else if (roll < 87) begin
            b.operation = ffra_pkg::OP_PROC;
        end else begin
            b.operation = ffra_pkg::OP_W'($urandom_range(3));
            b.frame     = ffra_pkg::FRAME_W'($urandom_range(3));
            if ($urandom_range(1)) b.count = ffra_pkg::COUNT_W'($urandom_range(64));
        end
        return b;
    endfunction

    task automatic issue_request(input ffra_pkg::t_in_beat req);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (o_in_stall);
        pending_replies = {pending_replies, compute_reply(req)};
    endtask

    task automatic wait_for_replies();
        i_in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [ffra_pkg::CAP_W-1:0] cap, input bit cpu);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= ffra_pkg::CFG_CAPACITY;
        i_cfg_data  <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        cap_reg = cap;
        i_cfg_index <= ffra_pkg::CFG_CPU_ONLY;
        i_cfg_data  <= ffra_pkg::CAP_W'(cpu);
        do @(posedge i_clk); while (!o_cfg_ready);
        cpu_only_reg = cpu;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_ops();
        send_idle_pct = 0;
        stall_pct     = 0;
        issue_request(make_request(ffra_pkg::OP_ALLOC, 0, 0, 0));
        issue_request(make_request(ffra_pkg::OP_ALLOC, 2047, 1023, 3));
        issue_request(make_request(ffra_pkg::OP_ALLOC, 1024, 0, 0));
        issue_request(make_request(ffra_pkg::OP_ALLOC, 1, 0, 0));
        issue_request(make_request(ffra_pkg::OP_FREE, 1024, 0, 0));
        issue_request(make_request(ffra_pkg::OP_FREE, 0, 5, 1));
        issue_request(make_request(ffra_pkg::OP_FREE, 2047, 1023, 3));
        issue_request(make_request(ffra_pkg::OP_PROC, 0, 0, 3));
        issue_request(make_request(ffra_pkg::OP_NOP, 2047, 1023, 3));
        issue_request(make_request(ffra_pkg::OP_PROC, 0, 0, 0));
        issue_request(make_request(ffra_pkg::OP_ALLOC, 8, 0, 0));
        issue_request(make_request(ffra_pkg::OP_ALLOC, 4, 0, 0));
        issue_request(make_request(ffra_pkg::OP_ALLOC, 16, 0, 0));
        issue_request(make_request(ffra_pkg::OP_FREE, 8, 0, 1));
        issue_request(make_request(ffra_pkg::OP_FREE, 2047, 1016, 1));
        issue_request(make_request(ffra_pkg::OP_PROC, 0, 0, 1));
        issue_request(make_request(ffra_pkg::OP_ALLOC, 10, 0, 0));
        issue_request(make_request(ffra_pkg::OP_ALLOC, 8, 0, 0));
        // free two neighbors, then ask for the merged span
        issue_request(make_request(ffra_pkg::OP_FREE, 4, 8, 2));
        issue_request(make_request(ffra_pkg::OP_FREE, 16, 12, 2));
        issue_request(make_request(ffra_pkg::OP_PROC, 0, 0, 2));
        issue_request(make_request(ffra_pkg::OP_ALLOC, 20, 0, 0));
        issue_request(make_request(ffra_pkg::OP_FREE, 1024, 0, 0));
        issue_request(make_request(ffra_pkg::OP_PROC, 0, 0, 0));
        wait_for_replies();
        live_ranges.delete();
    endtask

    task automatic test_free_overflow();
        send_idle_pct = 0;
        stall_pct     = 0;
        for (int n = 0; n <= QUEUE_DEPTH; n++) begin
            issue_request(make_request(ffra_pkg::OP_FREE, $urandom_range(4, 1), $urandom, 2));
        end
        issue_request(make_request(ffra_pkg::OP_PROC, 0, 0, 2));
        wait_for_replies();
    endtask

    task automatic test_config_sweep();
        logic [ffra_pkg::CAP_W-1:0] cap_set [6] =
            '{11'd1024, 11'd1, 11'd2047, 11'd16, 11'd512, 11'd1024};
        bit               cpu_set [6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
        int               send_tbl [4] = '{0, 66, 0, 30};
        int               stall_tbl [4] = '{0, 0, 66, 30};
        cap_set[4] = ffra_pkg::CAP_W'($urandom_range(1023, 17));
        foreach (cap_set[p]) begin
            write_config(cap_set[p], cpu_set[p]);
            foreach (send_tbl[m]) begin
                send_idle_pct = send_tbl[m];
                stall_pct     = stall_tbl[m];
                repeat (50) issue_request(random_request());
            end
            send_idle_pct = 0;
            stall_pct     = 0;
            wait_for_replies();
        end
    endtask

    always @(posedge i_clk) begin : check_replies
        ffra_pkg::t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_replies.size() == 0) begin
                $error("result beat with no request outstanding");
                error_count++;
            end else begin
                want = pending_replies.pop_front();
                if (o_out_data.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_out_data.status);
                    error_count++;
                end
                if (o_out_data.alloc_start !== want.alloc_start) begin
                    $error("alloc_start: expected %0d, actual %0d",
                           want.alloc_start, o_out_data.alloc_start);
                    error_count++;
                end
                if (o_out_data.alloc_count !== want.alloc_count) begin
                    $error("alloc_count: expected %0d, actual %0d",
                           want.alloc_count, o_out_data.alloc_count);
                    error_count++;
                end
                if (o_out_data.alloc_cpu_only !== want.alloc_cpu_only) begin
                    $error("alloc_cpu_only: expected %0d, actual %0d",
                           want.alloc_cpu_only, o_out_data.alloc_cpu_only);
                    error_count++;
                end
                if (o_out_data.in_use !== want.in_use) begin
                    $error("in_use: expected %0d, actual %0d", want.in_use, o_out_data.in_use);
                    error_count++;
                end
            end
        end
        i_out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_out_stall <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        cap_reg       = ffra_pkg::CAPACITY_RST;
        cpu_only_reg  = 1'b0;
        slots_used    = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        foreach (slot_free[i]) slot_free[i] = 1'b1;
        foreach (queue_fill[f]) queue_fill[f] = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_ops();
        test_free_overflow();
        test_config_sweep();

        wait_for_replies();
        repeat (100) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== first_fit_range_allocator_top.f =====
sv/ffra_pkg.sv
sv/ffra_slot_map.sv
sv/ffra_pend_mem.sv
sv/ffra_ctrl.sv
sv/first_fit_range_allocator_top.sv
tb/first_fit_range_allocator_top_tb.sv
